// ----- hw/rtl/sle_pkg.sv -----
`timescale 1ns / 1ps
package sle_pkg;

   localparam logic [1:0] CMD_LOCATE = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;

   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_BADPOS   = 2'd1;
   localparam logic [1:0] STS_FULL     = 2'd2;
   localparam logic [1:0] STS_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  position;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  found_position;
      logic [15:0] removed_value;
      logic [7:0]  list_length;
   } rsp_type;

endpackage

// ----- hw/rtl/sequential_list_engine_core.sv -----
`timescale 1ns / 1ps
// channel  direction  handshake            beat payload
// req_     in         req_valid/req_stall  sle_pkg::req_type (command, position, value)
// rsp_     out        rsp_valid/rsp_stall  sle_pkg::rsp_type (status, found, removed, length)
//
// One command at a time; the entry memory has one read and one write port and moves one
// entry per cycle. Locate reads from the head and stops at the first match or at the end of
// the list; insert moves entries up from the tail, or writes the value directly when none
// move; delete moves the entries after the removed one down; rejected or unused commands go straight to the result.
// The next command can be taken in the same cycle as the result appears.
// Synchronous reset empties the list; memory contents are left as they are.
// A stalled result is held in the output register; the next command may start meanwhile.
module sequential_list_engine_core #(
   parameter int CAPACITY   = 128,
   parameter int ELEM_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sle_pkg::rsp_type rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = ((CW > 8) ? CW : 8) + 1;
   localparam int EW = ELEM_WIDTH;
   localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_LOCATE = 5'b00010,
      S_INSERT = 5'b00100,
      S_DELETE = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic [CW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [XW-1:0]    pos_ff, pos_in;
   logic [EW-1:0]    val_ff, val_in;
   sle_pkg::rsp_type res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sle_pkg::rsp_type rsp_ff, rsp_in;

   logic [EW-1:0]    mem [CAPACITY];
   logic [EW-1:0]    rd_data_ff;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [EW-1:0]    mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic             rd_issue;
   logic [CW-1:0]    idx_m1;
   logic [XW-1:0]    idx_x, cmp_x, cnt_x, pos_m1, cmp_m1;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = idx_ff;
      rd_vld_in    = 1'b0;
      pos_in       = pos_ff;
      val_in       = val_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      idx_m1       = idx_ff - CW'(1);
      idx_x        = XW'(idx_ff);
      cmp_x        = XW'(cmp_idx_ff);
      cnt_x        = XW'(count_ff);
      pos_m1       = pos_ff - XW'(1);
      cmp_m1       = cmp_x - XW'(1);
      mem_we       = 1'b0;
      mem_waddr    = cmp_idx_ff[AW-1:0];
      mem_wdata    = rd_data_ff;
      mem_raddr    = idx_ff[AW-1:0];
      rd_issue     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in = XW'(req_data.position);
               val_in = EW'(req_data.value);
               res_in = '0;
               res_in.status = sle_pkg::STS_OK;
               case (req_data.command)
                  sle_pkg::CMD_LOCATE: begin
                     idx_in   = '0;
                     state_in = S_LOCATE;
                  end
                  sle_pkg::CMD_INSERT: begin
                     if (req_data.position == 8'd0 ||
                         XW'(req_data.position) > cnt_x + XW'(1)) begin
                        res_in.status = sle_pkg::STS_BADPOS;
                        state_in      = S_DONE;
                     end else if (cnt_x == CAP_X) begin
                        res_in.status = sle_pkg::STS_FULL;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = S_INSERT;
                     end
                  end
                  sle_pkg::CMD_DELETE: begin
                     if (req_data.position == 8'd0 || XW'(req_data.position) > cnt_x) begin
                        res_in.status = sle_pkg::STS_BADPOS;
                        state_in      = S_DONE;
                     end else begin
                        idx_in   = CW'(XW'(req_data.position) - XW'(1));
                        state_in = S_DELETE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_LOCATE: begin
            rd_issue = (idx_ff < count_ff);
            if (rd_vld_ff && rd_data_ff == val_ff) begin
               rd_issue              = 1'b0;
               res_in.found_position = 8'(cmp_x + XW'(1));
               state_in              = S_DONE;
            end else if (!rd_issue && !rd_vld_ff) begin
               res_in.status = sle_pkg::STS_NOTFOUND;
               state_in      = S_DONE;
            end
            if (rd_issue) begin
               idx_in    = idx_ff + CW'(1);
               rd_vld_in = 1'b1;
            end
         end
         S_INSERT: begin
            // walk from the tail down, each entry moves up by one
            mem_raddr = idx_m1[AW-1:0];
            rd_issue  = (idx_x >= pos_ff) && (idx_ff != '0);
            if (rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = cmp_idx_ff[AW-1:0];
               mem_wdata = rd_data_ff;
            end
            if (rd_issue) begin
               idx_in     = idx_m1;
               cmp_idx_in = idx_ff;
               rd_vld_in  = 1'b1;
            end else if (!rd_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_m1[AW-1:0];
               mem_wdata = val_ff;
               count_in  = count_ff + CW'(1);
               state_in  = S_DONE;
            end
         end
         S_DELETE: begin
            // first read is the removed entry, the rest move down by one
            rd_issue = (idx_ff < count_ff);
            if (rd_vld_ff) begin
               if (cmp_x == pos_m1) begin
                  res_in.removed_value = 16'(rd_data_ff);
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = cmp_m1[AW-1:0];
                  mem_wdata = rd_data_ff;
               end
            end
            if (rd_issue) begin
               idx_in    = idx_ff + CW'(1);
               rd_vld_in = 1'b1;
            end else if (!rd_vld_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = res_ff;
               rsp_in.list_length = cnt_x[7:0];
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_vld_in) |-> (mem_waddr != mem_raddr))
      else $error("shift writes the entry being read");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == sle_pkg::STS_FULL) |->
         (rsp_data.list_length == CAP_X[7:0]))
      else $error("full status with list not full");

endmodule
